// File: rtl/core/msprle_pkg.sv
`default_nettype none
package msprle_pkg;

  localparam int CodeW  = 8;
  localparam int SizeW  = 16;
  localparam int RowW   = 14;
  localparam int PhaseW = 2;

  localparam logic [PhaseW-1:0] PH_CODE  = 2'd0;
  localparam logic [PhaseW-1:0] PH_COUNT = 2'd1;
  localparam logic [PhaseW-1:0] PH_VALUE = 2'd2;
  localparam logic [PhaseW-1:0] PH_LIT   = 2'd3;

  localparam logic [RowW-1:0] ROW_BYTES_RESET = 14'd80;

  typedef logic [RowW-1:0] row_t;

  typedef struct packed {
    logic [CodeW-1:0] code_byte;
    logic             line_start;
    logic [SizeW-1:0] line_size;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] out_byte;
    logic [CodeW-1:0] repeat_res;
    logic             last_in_line;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    logic      have;
    out_item_t item;
  } step_res_t;

endpackage
`default_nettype wire

// File: rtl/core/msprle_stream_if.sv
`default_nettype none
interface msprle_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/msprle_decode.sv
`default_nettype none
module msprle_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  msprle_pkg::in_item_t item,
  input  logic                 fire,
  input  logic                 cfg_we,
  input  msprle_pkg::row_t     cfg_data,
  output msprle_pkg::step_res_t res
);
  import msprle_pkg::*;

  logic [PhaseW-1:0] phase, phase_next;
  logic [CodeW-1:0]  literal_left, literal_left_next;
  logic [CodeW-1:0]  run_count, run_count_next;
  logic [SizeW-1:0]  compressed_left, compressed_left_next;
  row_t              decoded_count, decoded_count_next;
  row_t              row_bytes;

  logic              active;
  logic              last;
  logic              have;
  logic [SizeW-1:0]  size_eff;
  logic [SizeW-1:0]  cl_eff;
  logic [PhaseW-1:0] ph_eff;
  logic [CodeW-1:0]  ll_eff;
  logic [CodeW-1:0]  rc_eff;
  row_t              dc_eff;
  logic [CodeW-1:0]  val;
  logic [CodeW-1:0]  rep;
  logic [CodeW-1:0]  rep_clip;
  row_t              room;
  logic              ovf;

  always_comb begin
    size_eff = (item.line_size == '0) ? 16'd1 : item.line_size;
    active   = item.line_start || (compressed_left != '0);
    cl_eff   = item.line_start ? size_eff : compressed_left;
    ph_eff   = item.line_start ? PH_CODE : phase;
    ll_eff   = item.line_start ? '0 : literal_left;
    rc_eff   = item.line_start ? '0 : run_count;
    dc_eff   = item.line_start ? '0 : decoded_count;

    compressed_left_next = cl_eff - 16'd1;
    last                 = (compressed_left_next == '0);

    phase_next        = ph_eff;
    literal_left_next = ll_eff;
    run_count_next    = rc_eff;
    have              = 1'b0;
    val               = '0;
    rep               = '0;

    unique case (ph_eff)
      PH_CODE: begin
        if (item.code_byte == '0) begin
          phase_next = PH_COUNT;
        end else begin
          literal_left_next = item.code_byte;
          phase_next        = PH_LIT;
        end
      end
      PH_COUNT: begin
        run_count_next = item.code_byte;
        phase_next     = PH_VALUE;
      end
      PH_VALUE: begin
        phase_next = PH_CODE;
        val        = item.code_byte;
        rep        = rc_eff;
        have       = (rc_eff != '0) || last;
      end
      PH_LIT: begin
        val               = item.code_byte;
        rep               = 8'd1;
        have              = 1'b1;
        literal_left_next = ll_eff - 8'd1;
        if (literal_left_next == '0) begin
          phase_next = PH_CODE;
        end
      end
    endcase

    // end of line: empty marker if nothing else, drop unread literals
    if (last) begin
      if (!have) begin
        have = 1'b1;
        val  = '0;
        rep  = '0;
      end
      phase_next        = PH_CODE;
      literal_left_next = '0;
    end

    room               = (row_bytes > dc_eff) ? (row_bytes - dc_eff) : '0;
    ovf                = {6'd0, rep} > room;
    rep_clip           = ovf ? room[CodeW-1:0] : rep;
    decoded_count_next = dc_eff + {6'd0, rep_clip};

    res.have              = active && have;
    res.item.out_byte     = val;
    res.item.repeat_res   = rep_clip;
    res.item.last_in_line = last;
    res.item.overflow     = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CODE;
      literal_left    <= '0;
      run_count       <= '0;
      compressed_left <= '0;
      decoded_count   <= '0;
    end else if (fire && active) begin
      phase           <= phase_next;
      literal_left    <= literal_left_next;
      run_count       <= run_count_next;
      compressed_left <= compressed_left_next;
      decoded_count   <= decoded_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= ROW_BYTES_RESET;
    end else if (cfg_we) begin
      row_bytes <= cfg_data;
    end
  end

`ifndef SYNTH
  a_lit_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LIT) |-> (literal_left != '0))
    else $error("literal phase with no literal bytes left");

  a_idle_phase_code: assert property (@(posedge clk) disable iff (rst)
    (compressed_left == '0) |-> (phase == PH_CODE))
    else $error("line finished outside code phase");

  a_hold_without_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(compressed_left) && $stable(decoded_count))
    else $error("line state moved without an item");
`endif
endmodule
`default_nettype wire

// File: rtl/core/msprle_outbuf.sv
`default_nettype none
module msprle_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  msprle_pkg::out_item_t load_item,
  output logic                  can_take,
  msprle_stream_if.source       result
);
  import msprle_pkg::*;

  logic      valid;
  out_item_t item;

  assign can_take       = !valid || result.ready;
  assign result.valid   = valid;
  assign result.payload = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      item <= load_item;
    end
  end

`ifndef SYNTH
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && can_take) |=> valid)
    else $error("loaded result not presented");
`endif
endmodule
`default_nettype wire

// File: rtl/core/msp_rle_scanline_decoder.sv
`default_nettype none
// Run-length scanline decoder: takes one compressed byte per cycle while the result
// output is not stalled, and gives at most one (value, repeat) item per byte. Each
// byte is held in an input register, decoded combinationally against the phase and
// line counters, and the result is placed in an output register; a stalled output
// holds the byte in the input register. The row width register is written over the
// cfg channel, which is always ready; write it only while no bytes are in flight.
module msp_rle_scanline_decoder (
  input  logic          clk,
  input  logic          rst,
  msprle_stream_if.sink cfg,
  msprle_stream_if.sink stream,
  msprle_stream_if.source result
);
  import msprle_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  logic      out_can_take;
  step_res_t step;

  assign s1_adv       = s1_valid && out_can_take;
  assign stream.ready = !s1_valid || s1_adv;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      s1_item <= stream.payload;
    end
  end

  msprle_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .item     (s1_item),
    .fire     (s1_adv),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.payload),
    .res      (step)
  );

  msprle_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && step.have),
    .load_item (step.item),
    .can_take  (out_can_take),
    .result    (result)
  );

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> stream.ready)
    else $error("input stalled with empty input register");
`endif
endmodule
`default_nettype wire

// File: dv/tb_msp_rle_scanline_decoder.sv
`default_nettype none
module tb_msp_rle_scanline_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import msprle_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int SettleCycles = 8;
  localparam int LongHold = 400;
  localparam int ItemsPerPhase = 172;
  localparam int NumPhases = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msprle_stream_if #(.payload_t(row_t)) cfg_if ();
  msprle_stream_if #(.payload_t(in_item_t)) in_if ();
  msprle_stream_if #(.payload_t(out_item_t)) res_if ();

  msp_rle_scanline_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .stream (in_if),
    .result (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  row_t        row_cfg = ROW_BYTES_RESET;
  logic [1:0]  phase_q = PH_CODE;
  logic [7:0]  lit_left = '0;
  logic [7:0]  run_cnt = '0;
  logic [15:0] comp_left = '0;
  row_t        dec_cnt = '0;

  in_item_t  pend_items[$];
  out_item_t expected_runs[$];
  logic [7:0] line_buf[$];

  int n_queued = 0;
  int n_real = 0;
  int n_taken = 0;
  int cfg_writes = 0;
  int n_err = 0;
  int cycles = 0;
  int src_gap_max = 0;
  int snk_gap_max = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit in_took = 1'b0;
  bit res_took = 1'b0;
  bit hold_req = 1'b0;

  function automatic step_res_t decode_byte(in_item_t it);
    step_res_t r;
    logic last;
    logic have;
    logic [7:0] val;
    int rep;
    int room;
    r = '0;
    have = 1'b0;
    val = '0;
    rep = 0;
    if (it.line_start) begin
      comp_left = (it.line_size == '0) ? 16'd1 : it.line_size;
      dec_cnt = '0;
      phase_q = PH_CODE;
      lit_left = '0;
      run_cnt = '0;
    end else if (comp_left == '0) begin
      return r;
    end
    comp_left = comp_left - 16'd1;
    last = (comp_left == '0);
    case (phase_q)
      PH_CODE: begin
        if (it.code_byte == '0) begin
          phase_q = PH_COUNT;
        end else begin
          lit_left = it.code_byte;
          phase_q = PH_LIT;
        end
      end
      PH_COUNT: begin
        run_cnt = it.code_byte;
        phase_q = PH_VALUE;
      end
      PH_VALUE: begin
        phase_q = PH_CODE;
        val = it.code_byte;
        rep = int'(run_cnt);
        have = (rep != 0) || last;
      end
      default: begin
        val = it.code_byte;
        rep = 1;
        have = 1'b1;
        lit_left = lit_left - 8'd1;
        if (lit_left == '0) phase_q = PH_CODE;
      end
    endcase
    if (last) begin
      if (!have) begin
        have = 1'b1;
        val = '0;
        rep = 0;
      end
      phase_q = PH_CODE;
      lit_left = '0;
    end
    if (!have) return r;
    room = (int'(row_cfg) > int'(dec_cnt)) ? int'(row_cfg) - int'(dec_cnt) : 0;
    r.item.overflow = (rep > room);
    if (rep > room) rep = room;
    dec_cnt = row_t'(int'(dec_cnt) + rep);
    r.have = 1'b1;
    r.item.out_byte = val;
    r.item.repeat_res = 8'(rep);
    r.item.last_in_line = last;
    return r;
  endfunction

  function automatic int draw_wait(int maxw);
    if (maxw == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, maxw);
  endfunction

  task automatic note_error(string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endtask

  // sample side
  always @(posedge clk) begin
    step_res_t sr;
    out_item_t want;
    out_item_t got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        res_took = 1'b1;
        if (expected_runs.size() == 0) begin
          note_error($sformatf("unexpected result item: byte=%02h rep=%0d last=%0b ovf=%0b",
                               got.out_byte, got.repeat_res, got.last_in_line, got.overflow));
        end else begin
          want = expected_runs.pop_front();
          if (got.out_byte !== want.out_byte || got.repeat_res !== want.repeat_res ||
              got.last_in_line !== want.last_in_line || got.overflow !== want.overflow) begin
            note_error($sformatf(
              {"mismatch: exp byte=%02h rep=%0d last=%0b ovf=%0b",
               " got byte=%02h rep=%0d last=%0b ovf=%0b"},
              want.out_byte, want.repeat_res, want.last_in_line, want.overflow,
              got.out_byte, got.repeat_res, got.last_in_line, got.overflow));
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        row_cfg = cfg_if.payload;
        cfg_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        sr = decode_byte(in_if.payload);
        if (sr.have) expected_runs.insert(expected_runs.size(), sr.item);
        n_taken++;
        in_took = 1'b1;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      in_took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pend_items.size() > 0) begin
        in_if.payload <= pend_items.pop_front();
        in_if.valid <= 1'b1;
        gap_left = draw_wait(src_gap_max);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink with stalls
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_took) begin
        res_took = 1'b0;
        stall_left = draw_wait(snk_gap_max);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic [7:0] b, logic st, logic [15:0] sz, bit counted);
    in_item_t it;
    it.code_byte = b;
    it.line_start = st;
    it.line_size = sz;
    pend_items.insert(pend_items.size(), it);
    n_queued++;
    if (counted) n_real++;
  endtask

  task automatic push_line(logic [15:0] sz, int n);
    for (int i = 0; i < n; i++) begin
      push_item(line_buf[i], i == 0, (i == 0) ? sz : 16'($urandom), 1'b1);
    end
  endtask

  task automatic gen_line();
    int mode;
    int nseq;
    int n;
    int sz;
    mode = $urandom_range(0, 9);
    nseq = $urandom_range(1, 6);
    line_buf.delete();
    repeat (nseq) begin
      if ($urandom_range(0, 1) == 1) begin
        line_buf.insert(line_buf.size(), 8'h00);
        line_buf.insert(line_buf.size(),
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
        line_buf.insert(line_buf.size(), 8'($urandom));
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
        line_buf.insert(line_buf.size(), 8'(n));
        repeat (n) line_buf.insert(line_buf.size(), 8'($urandom));
      end
    end
    case (mode)
      6: push_line(16'd0, 1);
      7: begin
        sz = $urandom_range(1, line_buf.size());
        push_line(16'(sz), sz);
      end
      8: push_line(16'($urandom_range(line_buf.size() + 1, 65535)),
                   $urandom_range(1, line_buf.size()));
      9: begin
        push_line(16'(line_buf.size()), line_buf.size());
        repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0, 16'($urandom), 1'b0);
      end
      default: push_line(16'(line_buf.size()), line_buf.size());
    endcase
  endtask

  task automatic drain_results();
    do @(negedge clk); while (n_taken != n_queued || expected_runs.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_row_bytes(row_t v);
    int n0;
    n0 = cfg_writes;
    cfg_if.payload <= v;
    cfg_if.valid <= 1'b1;
    do @(negedge clk); while (cfg_writes == n0);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    row_t rows[NumPhases];
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    res_if.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed lines at the reset row width
    line_buf = '{8'h00};
    push_line(16'd0, 1);
    line_buf = '{8'h00, 8'h00, 8'hAA};
    push_line(16'd3, 3);
    line_buf = '{8'h00, 8'h00, 8'h55, 8'h01};
    push_line(16'd4, 4);
    line_buf = '{8'h02, 8'hFF, 8'h00, 8'h00, 8'hFF};
    push_line(16'd5, 5);
    line_buf = '{8'h00, 8'hFF, 8'hFF, 8'h01, 8'h3C};
    push_line(16'd5, 5);
    line_buf = '{8'h05, 8'h11, 8'h22};
    push_line(16'd10, 3);
    line_buf = '{8'h7F};
    push_line(16'hFFFF, 1);
    line_buf = '{8'h01, 8'h80};
    push_line(16'd2, 2);
    push_item(8'h00, 1'b0, 16'hFFFF, 1'b0);
    push_item(8'hFF, 1'b0, 16'h0000, 1'b0);

    rows[0] = row_t'(8192);
    rows[1] = row_t'(1);
    rows[2] = row_t'($urandom_range(2, 40));
    rows[3] = row_t'($urandom_range(1, 8192));
    rows[4] = row_t'(16);
    rows[5] = ROW_BYTES_RESET;
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_row_bytes(rows[p]);
      src_gap_max = (p == 0) ? 0 : 18;
      snk_gap_max = (p == 0) ? 0 : 18;
      if (p == 2) hold_req = 1'b1;
      while (n_real < 26 + (p + 1) * ItemsPerPhase) gen_line();
    end
    drain_results();
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: msp_rle_scanline_decoder.f
rtl/core/msprle_pkg.sv
rtl/core/msprle_stream_if.sv
rtl/core/msprle_decode.sv
rtl/core/msprle_outbuf.sv
rtl/core/msp_rle_scanline_decoder.sv
dv/tb_msp_rle_scanline_decoder.sv
